// ===== hw/rtl/cdrc_pkg.sv =====
// Shared constants and pipeline stage types for the clock drift ratio controller.
`timescale 1ns / 1ps

package cdrc_pkg;

    // Fixed-point unity for the Q1.23 adjustment.
    localparam logic [23:0] ONE_Q23 = 24'd8388608;

    // Ticks shorter than this carry no result.
    localparam logic [19:0] MIN_ELAPSED_US = 20'd50000;

    // Buffer fill target in milliseconds.
    localparam logic [11:0] TARGET_MS = 12'd300;

    // q = round(err * 2^23 / 6000) = 1398 * err + floor((76 * err + 375) / 750).
    localparam logic [10:0] ERR_WHOLE   = 11'd1398;
    localparam logic [6:0]  ERR_FRAC    = 7'd76;
    localparam logic [8:0]  ERR_BIAS    = 9'd375;
    // ceil(2^28 / 750); exact for the quotient over the whole fill range.
    localparam logic [18:0] ERR_RECIP   = 19'd357914;
    localparam int          ERR_SHIFT   = 28;

    // Slew limit m = floor((elapsed * 2^16 + 390625) / 781250).
    // A reciprocal estimate is at most one low and is corrected in the next stage.
    localparam logic [28:0] SLEW_RECIP  = 29'd360287970;
    localparam logic [37:0] SLEW_DIV    = 38'd781250;
    localparam logic [37:0] SLEW_BIAS   = 38'd390625;

    // Product rounding: add half an LSB of Q1.23 before dropping 23 bits.
    localparam logic [56:0] RATIO_ROUND = 57'd4194304;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_NOMINAL_RATIO  = 2'd0,
        CFG_OVERFLOW_LIMIT = 2'd1,
        CFG_UNDERFLOW_LIMIT = 2'd2
    } cfg_index_t;

    // Accepted tick that qualifies for an update.
    typedef struct packed {
        logic [19:0] elapsed;
        logic [11:0] fill;
    } s1_t;

    // Partial results for the desired adjustment and the slew limit.
    typedef struct packed {
        logic [19:0] elapsed;
        logic [16:0] slew_est;
        logic        err_neg;
        logic [11:0] err_mag;
        logic [8:0]  err_quot;
        logic        critical;
    } s2_t;

    // Operands of the adjustment update.
    typedef struct packed {
        logic [23:0] desired;
        logic [16:0] slew_max;
        logic        critical;
    } s3_t;

    // Updated adjustment with the episode status of the tick.
    typedef struct packed {
        logic [23:0] adjust;
        logic        critical;
        logic        entered;
        logic [15:0] episodes;
    } s4_t;

endpackage

// ===== hw/rtl/clock_drift_ratio_controller_core.sv =====
// Top level of the clock drift ratio controller: a five-register pipeline.
`timescale 1ns / 1ps

// Each qualifying adjust tick (elapsed_us of at least 50000 and link_up set) gives one
// result, which reaches the outputs after passing through all five registers; other ticks
// are absorbed with no result and leave the state alone. One request is taken in every
// cycle unless stalled. The pipeline holds an input register, two stages that form the
// desired adjustment and the slew limit, the stage that updates the stored adjustment
// and the episode latch, and the output register that holds the saturated ratio
// product. Any stage moves on whenever the one after it is free, so a waiting result
// blocks new requests only once all five registers hold qualifying ticks.
// Configuration writes take effect at once and are meant for idle periods.
module clock_drift_ratio_controller_core
    import cdrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [19:0] elapsed_us,
    input  logic [11:0] fill_ms,
    input  logic        link_up,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] ratio,
    output logic        critical,
    output logic        critical_entered,
    output logic [15:0] episode_count
);

    // Configuration registers.
    logic [31:0] nominal_ratio_reg;
    logic [11:0] overflow_limit_reg;
    logic [11:0] underflow_limit_reg;

    // Controller state.
    logic [23:0] adjust_reg;
    logic [23:0] adjust_next;
    logic        latched_reg;
    logic        latched_next;
    logic [15:0] episodes_reg;
    logic [15:0] episodes_next;

    // Pipeline stages.
    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic        s3_valid_reg;
    logic        s4_valid_reg;
    logic        out_valid_reg;
    s1_t         s1_reg;
    s1_t         s1_next;
    s2_t         s2_reg;
    s2_t         s2_next;
    s3_t         s3_reg;
    s3_t         s3_next;
    s4_t         s4_reg;
    s4_t         s4_next;
    logic [31:0] ratio_reg;
    logic [31:0] ratio_next;
    logic        critical_reg;
    logic        entered_reg;
    logic [15:0] count_reg;

    logic        out_free;
    logic        s4_free;
    logic        s3_free;
    logic        s2_free;
    logic        s1_free;
    logic        in_take;

    logic [18:0] err_num;
    logic [37:0] err_prod;
    logic [48:0] slew_prod;
    logic [37:0] slew_lhs;
    logic [37:0] slew_rhs;
    logic [22:0] err_q;
    logic [24:0] diff_up;
    logic [24:0] diff_down;
    logic [56:0] ratio_prod;

    // Handshake chain: a stage may load when it is empty or its content leaves.
    assign out_free = !out_valid_reg || out_ready;
    assign s4_free  = !s4_valid_reg || out_free;
    assign s3_free  = !s3_valid_reg || s4_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;
    assign in_take  = in_valid && in_ready && link_up && (elapsed_us >= MIN_ELAPSED_US);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_ratio_reg   <= 32'd16777216;
            overflow_limit_reg  <= 12'd1600;
            underflow_limit_reg <= 12'd20;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_NOMINAL_RATIO:   nominal_ratio_reg   <= cfg_data;
                CFG_OVERFLOW_LIMIT:  overflow_limit_reg  <= cfg_data[11:0];
                CFG_UNDERFLOW_LIMIT: underflow_limit_reg <= cfg_data[11:0];
                default:             ;
            endcase
        end
    end

    // Stage 1 input register.
    always_comb
    begin
        s1_next.elapsed = elapsed_us;
        s1_next.fill    = fill_ms;
    end

    // Stage 2: fill error split, reciprocal products and the critical compare.
    always_comb
    begin
        s2_next.elapsed = s1_reg.elapsed;
        if (s1_reg.fill > TARGET_MS)
        begin
            s2_next.err_neg = 1'b1;
            s2_next.err_mag = s1_reg.fill - TARGET_MS;
        end
        else
        begin
            s2_next.err_neg = 1'b0;
            s2_next.err_mag = TARGET_MS - s1_reg.fill;
        end
        err_num  = 19'(s2_next.err_mag) * 19'(ERR_FRAC) + 19'(ERR_BIAS);
        err_prod = 38'(err_num) * 38'(ERR_RECIP);
        s2_next.err_quot = err_prod[ERR_SHIFT+8:ERR_SHIFT];
        slew_prod = 49'(s1_reg.elapsed) * 49'(SLEW_RECIP) + 49'(33'h0_8000_0000);
        s2_next.slew_est = slew_prod[48:32];
        s2_next.critical = (s1_reg.fill > overflow_limit_reg)
                        || (s1_reg.fill < underflow_limit_reg);
    end

    // Stage 3: assemble the desired adjustment and correct the slew estimate.
    always_comb
    begin
        err_q = 23'(s2_reg.err_mag) * 23'(ERR_WHOLE) + 23'(s2_reg.err_quot);
        if (s2_reg.err_neg)
            s3_next.desired = ONE_Q23 - 24'(err_q);
        else
            s3_next.desired = ONE_Q23 + 24'(err_q);
        slew_lhs = (38'(s2_reg.slew_est) + 38'd1) * SLEW_DIV;
        slew_rhs = {2'b00, s2_reg.elapsed, 16'h0000} + SLEW_BIAS;
        if (slew_lhs <= slew_rhs)
            s3_next.slew_max = s2_reg.slew_est + 17'd1;
        else
            s3_next.slew_max = s2_reg.slew_est;
        s3_next.critical = s2_reg.critical;
    end

    // Stage 4: slew-limited move toward the desired value and episode tracking.
    // The result always lies between the old and the desired value, so it stays in range.
    always_comb
    begin
        diff_up   = {1'b0, s3_reg.desired} - {1'b0, adjust_reg};
        diff_down = {1'b0, adjust_reg} - {1'b0, s3_reg.desired};
        if (s3_reg.desired >= adjust_reg)
        begin
            if (diff_up > 25'(s3_reg.slew_max))
                adjust_next = adjust_reg + 24'(s3_reg.slew_max);
            else
                adjust_next = s3_reg.desired;
        end
        else
        begin
            if (diff_down > 25'(s3_reg.slew_max))
                adjust_next = adjust_reg - 24'(s3_reg.slew_max);
            else
                adjust_next = s3_reg.desired;
        end

        latched_next     = latched_reg;
        episodes_next    = episodes_reg;
        s4_next.entered  = 1'b0;
        if (s3_reg.critical && !latched_reg)
        begin
            latched_next    = 1'b1;
            episodes_next   = episodes_reg + 16'd1;
            s4_next.entered = 1'b1;
        end
        else if (!s3_reg.critical)
        begin
            latched_next = 1'b0;
        end
        s4_next.adjust   = adjust_next;
        s4_next.critical = s3_reg.critical;
        s4_next.episodes = episodes_next;
    end

    // Output stage: rounded and saturated ratio product.
    always_comb
    begin
        ratio_prod = 57'(nominal_ratio_reg) * 57'(s4_reg.adjust) + RATIO_ROUND;
        if (ratio_prod[56:55] != 2'b00)
            ratio_next = 32'hFFFF_FFFF;
        else
            ratio_next = ratio_prod[54:23];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            adjust_reg    <= ONE_Q23;
            latched_reg   <= 1'b0;
            episodes_reg  <= 16'd0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= in_take;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
            if (s4_free)
                s4_valid_reg <= s3_valid_reg;
            if (out_free)
                out_valid_reg <= s4_valid_reg;
            if (s3_valid_reg && s4_free)
            begin
                adjust_reg   <= adjust_next;
                latched_reg  <= latched_next;
                episodes_reg <= episodes_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_reg <= s1_next;
        if (s1_valid_reg && s2_free)
            s2_reg <= s2_next;
        if (s2_valid_reg && s3_free)
            s3_reg <= s3_next;
        if (s3_valid_reg && s4_free)
            s4_reg <= s4_next;
        if (s4_valid_reg && out_free)
        begin
            ratio_reg    <= ratio_next;
            critical_reg <= s4_reg.critical;
            entered_reg  <= s4_reg.entered;
            count_reg    <= s4_reg.episodes;
        end
    end

    assign out_valid        = out_valid_reg;
    assign ratio            = ratio_reg;
    assign critical         = critical_reg;
    assign critical_entered = entered_reg;
    assign episode_count    = count_reg;

endmodule

// ===== hw/rtl/cdrc_checker.sv =====
// Port-level checks for the clock drift ratio controller, bound to the top level.
`timescale 1ns / 1ps

module cdrc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] ratio,
    input logic        critical,
    input logic        critical_entered,
    input logic [15:0] episode_count
);

    // Status of the last result taken downstream.
    logic [15:0] last_count_reg;
    logic        last_critical_reg;
    logic        out_take;

    assign out_take = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg    <= 16'd0;
            last_critical_reg <= 1'b0;
        end
        else if (out_take)
        begin
            last_count_reg    <= episode_count;
            last_critical_reg <= critical;
        end
    end

    // A result that is held back keeps its ratio and episode count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ratio) && $stable(episode_count))
    else $error("held result changed before it was taken");

    // An episode starts only on a critical tick that follows a non-critical one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> critical_entered == (critical && !last_critical_reg))
    else $error("episode entry flag does not match the critical history");

    // The episode count advances by one exactly when an episode starts.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && critical_entered |-> episode_count == last_count_reg + 16'd1)
    else $error("episode count did not advance on a new episode");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !critical_entered |-> episode_count == last_count_reg)
    else $error("episode count changed without a new episode");

endmodule

bind clock_drift_ratio_controller_core cdrc_checker u_cdrc_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .ratio            (ratio),
    .critical         (critical),
    .critical_entered (critical_entered),
    .episode_count    (episode_count)
);
